/* rtl/mbsp_pkg.sv */
// Package for the MIDI byte stream parser: transaction payload types, control struct,
// status byte constants and the message length function.
// No dependencies.
`timescale 1ns / 1ps

package mbsp_pkg;

    localparam int TIME_W = 63;

    typedef struct packed {
        logic [7:0]        midi_byte;
        logic [TIME_W-1:0] time_ns;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        msg_status;
        logic [6:0]        msg_data1;
        logic [6:0]        msg_data2;
        logic [TIME_W-1:0] msg_time_ns;
    } out_item_t;

    typedef struct packed {
        logic consume;
        logic emit;
    } core_ctrl_t;

    localparam logic [7:0] REALTIME_FIRST = 8'hF8;
    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] SYSEX_END      = 8'hF7;
    localparam logic [7:0] SYSTEM_FIRST   = 8'hF0;
    localparam logic [7:0] MTC_QUARTER    = 8'hF1;
    localparam logic [7:0] SONG_POSITION  = 8'hF2;
    localparam logic [7:0] SONG_SELECT    = 8'hF3;
    localparam logic [7:0] NO_STATUS      = 8'h00;
    localparam logic [3:0] HI_PROGRAM     = 4'hC;
    localparam logic [3:0] HI_PRESSURE    = 4'hD;

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    function automatic logic [1:0] msg_length(input logic [7:0] st);
        logic [1:0] len;
        len = CNT_ONE;
        if (!st[7]) begin
            len = CNT_EMPTY;
        end else if (st < SYSTEM_FIRST) begin
            len = (st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE) ? CNT_TWO : CNT_THREE;
        end else if (st == MTC_QUARTER || st == SONG_SELECT) begin
            len = CNT_TWO;
        end else if (st == SONG_POSITION) begin
            len = CNT_THREE;
        end
        return len;
    endfunction

endpackage

/* rtl/mbsp_core.sv */
// Parser state and per-byte decode: SysEx skipping, running status and message assembly.
// Depends on mbsp_pkg.
`timescale 1ns / 1ps

module mbsp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  mbsp_pkg::in_item_t   item,
    input  logic                 out_free,
    output mbsp_pkg::core_ctrl_t ctrl,
    output mbsp_pkg::out_item_t  result
);

    logic       in_sysex_reg, in_sysex_next;
    logic [7:0] running_reg, running_next;
    logic [7:0] pend_status_reg, pend_status_next;
    logic [6:0] pend_first_reg, pend_first_next;
    logic [1:0] pend_count_reg, pend_count_next;

    logic [7:0] b;
    logic [7:0] work_status;
    logic [6:0] work_first;
    logic [6:0] work_last;
    logic [1:0] work_count;
    logic [1:0] need;
    logic       msg_live;
    logic       emit;

    assign b = item.midi_byte;

    always_comb begin
        in_sysex_next    = in_sysex_reg;
        running_next     = running_reg;
        pend_status_next = pend_status_reg;
        pend_first_next  = pend_first_reg;
        pend_count_next  = pend_count_reg;
        work_status      = pend_status_reg;
        work_first       = pend_first_reg;
        work_last        = 7'd0;
        work_count       = pend_count_reg;
        msg_live         = 1'b1;
        need             = mbsp_pkg::CNT_ONE;
        emit             = 1'b0;
        result.msg_status  = b;
        result.msg_data1   = 7'd0;
        result.msg_data2   = 7'd0;
        result.msg_time_ns = item.time_ns;

        if (b >= mbsp_pkg::REALTIME_FIRST) begin
            emit = 1'b1;
        end else if (in_sysex_reg) begin
            if (b == mbsp_pkg::SYSEX_END) begin
                in_sysex_next = 1'b0;
            end
        end else if (b == mbsp_pkg::SYSEX_START) begin
            in_sysex_next   = 1'b1;
            pend_count_next = mbsp_pkg::CNT_EMPTY;
            running_next    = mbsp_pkg::NO_STATUS;
        end else begin
            if (b[7]) begin
                work_status  = b;
                work_count   = mbsp_pkg::CNT_ONE;
                running_next = (b < mbsp_pkg::SYSTEM_FIRST) ? b : mbsp_pkg::NO_STATUS;
            end else if (pend_count_reg == mbsp_pkg::CNT_EMPTY
                         && running_reg == mbsp_pkg::NO_STATUS) begin
                msg_live = 1'b0;
            end else begin
                if (pend_count_reg == mbsp_pkg::CNT_EMPTY) begin
                    work_status = running_reg;
                    work_count  = mbsp_pkg::CNT_ONE;
                end
                if (work_count == mbsp_pkg::CNT_ONE) begin
                    work_first = b[6:0];
                    work_count = mbsp_pkg::CNT_TWO;
                end else begin
                    work_last  = b[6:0];
                    work_count = mbsp_pkg::CNT_THREE;
                end
            end
            need = mbsp_pkg::msg_length(work_status);
            if (msg_live) begin
                pend_status_next = work_status;
                pend_first_next  = work_first;
                if (need != mbsp_pkg::CNT_EMPTY && work_count >= need) begin
                    emit              = 1'b1;
                    pend_count_next   = mbsp_pkg::CNT_EMPTY;
                    result.msg_status = work_status;
                    result.msg_data1  = (need > mbsp_pkg::CNT_ONE) ? work_first : 7'd0;
                    result.msg_data2  = (need > mbsp_pkg::CNT_TWO) ? work_last : 7'd0;
                end else begin
                    pend_count_next = work_count;
                end
            end
        end
    end

    assign ctrl.emit    = item_valid && emit;
    assign ctrl.consume = item_valid && (!emit || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sysex_reg    <= 1'b0;
            running_reg     <= mbsp_pkg::NO_STATUS;
            pend_status_reg <= 8'd0;
            pend_first_reg  <= 7'd0;
            pend_count_reg  <= mbsp_pkg::CNT_EMPTY;
        end else if (ctrl.consume) begin
            in_sysex_reg    <= in_sysex_next;
            running_reg     <= running_next;
            pend_status_reg <= pend_status_next;
            pend_first_reg  <= pend_first_next;
            pend_count_reg  <= pend_count_next;
        end
    end

    // Running status only ever holds a channel status or nothing.
    a_running_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg == mbsp_pkg::NO_STATUS
        || (running_reg[7] && running_reg < mbsp_pkg::SYSTEM_FIRST))
        else $error("running status holds a non-channel value");

    // A complete message never stays pending.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_count_reg != mbsp_pkg::CNT_THREE)
        else $error("pending count reached three");

    // Inside SysEx only real-time bytes produce messages.
    a_sysex_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_sysex_reg && ctrl.emit) |-> b >= mbsp_pkg::REALTIME_FIRST)
        else $error("message emitted from SysEx content");

    // Every emitted message carries a status byte.
    a_emit_status: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> result.msg_status[7])
        else $error("emitted message lacks a status byte");

    // State only moves when the held byte is consumed.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.consume |=> $stable(pend_count_reg) && $stable(in_sysex_reg))
        else $error("parser state changed without a consumed byte");

endmodule

/* rtl/midi_byte_stream_parser.sv */
// Top level of the MIDI byte stream parser: input register, decode core and result register.
// Depends on mbsp_pkg and mbsp_core.
`timescale 1ns / 1ps

// Usage: the s_ channel carries one received MIDI byte and its arrival time per
// transaction. The m_ channel carries a completed short message: status, two data
// bytes (zero where the message is shorter) and the time of the byte that finished it.
// Real-time bytes come out at once as one-byte messages, even inside SysEx; SysEx
// content is dropped, as are stray data bytes with no status to attach to.
// Each input byte gives zero or one message. A message passes through the input
// register and then the result register before it can be taken from m_. One byte
// is taken every cycle while no byte waits on an occupied result register, since
// the decode is a single pass of logic between those two registers. When the
// receiver stalls, the result register holds its message; bytes that give no message
// keep flowing, and the input register fills and drops s_ready only once a byte
// needs the occupied result register. Reset clears running status, SysEx mode, any
// partly received message and the valid flags of both registers.

module midi_byte_stream_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mbsp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mbsp_pkg::out_item_t m_data
);

    logic                 in_valid_reg;
    mbsp_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    mbsp_pkg::out_item_t  out_item_reg;
    logic                 out_free;
    mbsp_pkg::core_ctrl_t ctrl;
    mbsp_pkg::out_item_t  result;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || ctrl.consume;

    mbsp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= ctrl.emit && ctrl.consume;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit && ctrl.consume) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // A message is never written over one still waiting for the receiver.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(ctrl.emit && ctrl.consume))
        else $error("result register overwritten while stalled");

    // A stalled message stays on m_ unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled message changed or dropped");

    // A held byte that is not consumed stays in the input register.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !ctrl.consume) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held input byte changed or dropped");

endmodule

/* verif/midi_byte_stream_parser_tb.sv */
// Self-checking testbench for the MIDI byte stream parser: directed and random byte streams,
// each expected message predicted in the bench and compared field by field on the m_ channel.
// Depends on mbsp_pkg and midi_byte_stream_parser.
`timescale 1ns / 1ps

module midi_byte_stream_parser_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 440;

    localparam logic [7:0] ST_NOTE_OFF     = 8'h80;
    localparam logic [7:0] ST_NOTE_ON      = 8'h90;
    localparam logic [7:0] ST_CONTROL      = 8'hB0;
    localparam logic [7:0] ST_PITCH_BEND   = 8'hE0;
    localparam logic [7:0] ST_CHANNEL_LAST = 8'hEF;
    localparam logic [7:0] ST_UNDEF_F4     = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5     = 8'hF5;
    localparam logic [7:0] ST_TUNE_REQUEST = 8'hF6;
    localparam logic [7:0] ST_SYS_RESET    = 8'hFF;

    localparam logic [mbsp_pkg::TIME_W-1:0] STAMP_ZERO = '0;
    localparam logic [mbsp_pkg::TIME_W-1:0] STAMP_MAX  = '1;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mbsp_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mbsp_pkg::out_item_t m_data;

    midi_byte_stream_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Parser state mirrored by the predictor.
    logic             sysex_active = 1'b0;
    logic [7:0]       run_status   = mbsp_pkg::NO_STATUS;
    logic [7:0]       pend_status  = mbsp_pkg::NO_STATUS;
    logic [6:0]       pend_data1   = '0;
    logic [1:0]       pend_count   = mbsp_pkg::CNT_EMPTY;

    mbsp_pkg::out_item_t expected_msgs[$];

    int send_idle_pct = 16;
    int recv_idle_pct = 84;
    int err_count     = 0;
    int bytes_sent    = 0;
    int msgs_checked  = 0;
    int sysex_seen    = 0;
    int realtime_seen = 0;
    int idle_cycles   = 0;

    function automatic int status_length(input logic [7:0] st);
        if (!st[7]) begin
            return 0;
        end
        if (st < mbsp_pkg::SYSTEM_FIRST) begin
            return (st[7:4] == mbsp_pkg::HI_PROGRAM
                    || st[7:4] == mbsp_pkg::HI_PRESSURE) ? 2 : 3;
        end
        case (st)
            mbsp_pkg::MTC_QUARTER, mbsp_pkg::SONG_SELECT: return 2;
            mbsp_pkg::SONG_POSITION: return 3;
            default: return 1;
        endcase
    endfunction

    function automatic logic [mbsp_pkg::TIME_W-1:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(15))
            0: return STAMP_ZERO;
            1: return STAMP_MAX;
            default: return r[mbsp_pkg::TIME_W-1:0];
        endcase
    endfunction

    task automatic predict_parse(input mbsp_pkg::in_item_t it);
        logic [7:0]          b;
        logic [6:0]          last_data;
        int                  need;
        mbsp_pkg::out_item_t msg;
        b = it.midi_byte;
        last_data = '0;
        if (b >= mbsp_pkg::REALTIME_FIRST) begin
            msg.msg_status  = b;
            msg.msg_data1   = '0;
            msg.msg_data2   = '0;
            msg.msg_time_ns = it.time_ns;
            expected_msgs.push_back(msg);
            realtime_seen++;
            return;
        end
        if (sysex_active) begin
            if (b == mbsp_pkg::SYSEX_END) begin
                sysex_active = 1'b0;
            end
            return;
        end
        if (b == mbsp_pkg::SYSEX_START) begin
            sysex_active = 1'b1;
            pend_count = mbsp_pkg::CNT_EMPTY;
            run_status = mbsp_pkg::NO_STATUS;
            sysex_seen++;
            return;
        end
        if (b[7]) begin
            pend_status = b;
            pend_count = mbsp_pkg::CNT_ONE;
            run_status = (b < mbsp_pkg::SYSTEM_FIRST) ? b : mbsp_pkg::NO_STATUS;
        end else begin
            if (pend_count == mbsp_pkg::CNT_EMPTY) begin
                if (run_status == mbsp_pkg::NO_STATUS) begin
                    return;
                end
                pend_status = run_status;
                pend_count = mbsp_pkg::CNT_ONE;
            end
            if (pend_count == mbsp_pkg::CNT_ONE) begin
                pend_data1 = b[6:0];
                pend_count = mbsp_pkg::CNT_TWO;
            end else begin
                last_data = b[6:0];
                pend_count = mbsp_pkg::CNT_THREE;
            end
        end
        need = status_length(pend_status);
        if (need == 0 || pend_count < need) begin
            return;
        end
        msg.msg_status  = pend_status;
        msg.msg_data1   = (need > 1) ? pend_data1 : '0;
        msg.msg_data2   = (need > 2) ? last_data : '0;
        msg.msg_time_ns = it.time_ns;
        expected_msgs.push_back(msg);
        pend_count = mbsp_pkg::CNT_EMPTY;
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic send_byte(input logic [7:0] b,
                             input logic [mbsp_pkg::TIME_W-1:0] stamp);
        mbsp_pkg::in_item_t it;
        it.midi_byte = b;
        it.time_ns   = stamp;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_parse(it);
        bytes_sent++;
    endtask

    task automatic send_any(input logic [7:0] b);
        send_byte(b, rand_stamp());
    endtask

    task automatic send_data();
        if ($urandom_range(15) == 0) begin
            send_any(8'($urandom_range(ST_SYS_RESET, mbsp_pkg::REALTIME_FIRST)));
        end
        send_any(8'($urandom_range(127)));
    endtask

    task automatic wait_for_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_msgs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        mbsp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_msgs.size() == 0) begin
                report_mismatch($sformatf("message %h with none expected", m_data));
            end else begin
                want = expected_msgs.pop_front();
                if (m_data.msg_status !== want.msg_status) begin
                    report_mismatch($sformatf("msg_status %h, expected %h",
                                              m_data.msg_status, want.msg_status));
                end
                if (m_data.msg_data1 !== want.msg_data1) begin
                    report_mismatch($sformatf("msg_data1 %h, expected %h",
                                              m_data.msg_data1, want.msg_data1));
                end
                if (m_data.msg_data2 !== want.msg_data2) begin
                    report_mismatch($sformatf("msg_data2 %h, expected %h",
                                              m_data.msg_data2, want.msg_data2));
                end
                if (m_data.msg_time_ns !== want.msg_time_ns) begin
                    report_mismatch($sformatf("msg_time_ns %h, expected %h",
                                              m_data.msg_time_ns, want.msg_time_ns));
                end
                msgs_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_stray_data();
        send_byte(8'h7F, STAMP_ZERO);
    endtask

    task automatic test_channel_messages();
        send_byte(ST_NOTE_ON, STAMP_ZERO);
        send_byte(8'h00, STAMP_ZERO);
        send_byte(mbsp_pkg::REALTIME_FIRST, STAMP_MAX);
        send_byte(8'h7F, STAMP_MAX);
        send_any(8'h55);
        send_any(8'h2A);
        send_any({mbsp_pkg::HI_PROGRAM, 4'hF});
        send_any(8'h7F);
        send_any({mbsp_pkg::HI_PRESSURE, 4'h0});
        send_any(8'h00);
        send_any(ST_PITCH_BEND);
        send_any(8'h12);
        send_any(ST_CONTROL);
    endtask

    task automatic test_system_common();
        send_any(mbsp_pkg::MTC_QUARTER);
        send_any(8'h00);
        send_any(mbsp_pkg::SONG_POSITION);
        send_any(8'h7F);
        send_any(8'h7F);
        send_any(mbsp_pkg::SONG_SELECT);
        send_any(8'h01);
        send_any(ST_UNDEF_F4);
        send_any(ST_TUNE_REQUEST);
        send_any(8'h2A);
    endtask

    task automatic test_sysex_and_realtime();
        send_any(mbsp_pkg::SYSEX_START);
        send_any(8'h12);
        send_any(ST_SYS_RESET);
        send_any(mbsp_pkg::SYSEX_END);
        send_any(mbsp_pkg::SYSEX_END);
    endtask

    task automatic test_random_traffic(input int n_items);
        int         first_sent;
        int         pick;
        int         len;
        logic [7:0] st;
        first_sent = bytes_sent;
        while (bytes_sent - first_sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                st = 8'($urandom_range(ST_CHANNEL_LAST, ST_NOTE_OFF));
                len = status_length(st);
                send_any(st);
                repeat ($urandom_range(4, 1)) begin
                    repeat (len - 1) send_data();
                end
            end else if (pick < 60) begin
                case ($urandom_range(6))
                    0: st = mbsp_pkg::MTC_QUARTER;
                    1: st = mbsp_pkg::SONG_POSITION;
                    2: st = mbsp_pkg::SONG_SELECT;
                    3: st = ST_UNDEF_F4;
                    4: st = ST_UNDEF_F5;
                    5: st = ST_TUNE_REQUEST;
                    default: st = mbsp_pkg::SYSEX_END;
                endcase
                len = status_length(st);
                send_any(st);
                repeat (len - 1) send_data();
            end else if (pick < 72) begin
                send_any(mbsp_pkg::SYSEX_START);
                repeat ($urandom_range(8)) begin
                    if ($urandom_range(7) == 0) begin
                        send_any(8'($urandom_range(ST_SYS_RESET, mbsp_pkg::REALTIME_FIRST)));
                    end else begin
                        send_any(8'($urandom_range(127)));
                    end
                end
                send_any(mbsp_pkg::SYSEX_END);
            end else if (pick < 80) begin
                send_any(8'($urandom_range(ST_SYS_RESET, mbsp_pkg::REALTIME_FIRST)));
            end else if (pick < 90) begin
                st = 8'($urandom_range(ST_CHANNEL_LAST, ST_NOTE_OFF));
                len = status_length(st);
                send_any(st);
                repeat ($urandom_range(len - 2)) send_data();
            end else begin
                repeat ($urandom_range(3, 1)) send_any(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_stray_data();
        test_channel_messages();
        test_system_common();
        test_sysex_and_realtime();
        wait_for_quiet();

        test_random_traffic(RANDOM_ITEMS);
        wait_for_quiet();

        send_idle_pct = 84;
        recv_idle_pct = 16;
        test_random_traffic(RANDOM_ITEMS);
        wait_for_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS);
        wait_for_quiet();

        if (expected_msgs.size() != 0) begin
            report_mismatch($sformatf("%0d messages never arrived", expected_msgs.size()));
        end

        $display("Sent %0d bytes and checked %0d messages, %0d of them real-time.",
                 bytes_sent, msgs_checked, realtime_seen);
        $display("Stream held %0d SysEx transfers; %0d mismatches found.",
                 sysex_seen, err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mbsp_pkg.sv
rtl/mbsp_core.sv
rtl/midi_byte_stream_parser.sv
verif/midi_byte_stream_parser_tb.sv
